// ===== rtl/core/ffcq_pkg.sv =====
package ffcq_pkg;

  // Command codes on the input port
  localparam logic [1:0] CMD_FEEDBACK = 2'd0;
  localparam logic [1:0] CMD_XFER_ERR = 2'd1;
  localparam logic [1:0] CMD_PLAYBACK = 2'd2;

  // Pattern geometry: eight frame counts of four bits make one ring row
  localparam int PAT_LEN   = 8;
  localparam int PAT_SHIFT = 3;
  localparam int FRAME_W   = 4;
  localparam int ROW_W     = PAT_LEN * FRAME_W;
  localparam int NUM_PAT   = 5;
  localparam logic [7:0] WIN_SPAN = 8'd4;

  typedef enum logic [1:0] {
    OP_FEEDBACK,
    OP_XFER_ERR,
    OP_PLAYBACK,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
    logic       good;
    logic       last;
    logic       win_hit;
    logic [2:0] pat_sel;
  } fq_entry_t;

  typedef struct packed {
    logic [3:0]  frame_count;
    logic        underrun;
    logic        silent;
    logic        synced;
    logic        warmed_up;
    logic [6:0]  occupancy;
    logic [31:0] overrun_total;
    logic [31:0] underrun_total;
    logic [7:0]  last_feedback;
  } res_t;

  localparam logic [7:0] WIN_BASE [4] = '{8'd42, 8'd46, 8'd86, 8'd94};
  localparam logic [3:0] NOMINAL  [4] = '{4'd5, 4'd6, 4'd11, 4'd12};

  localparam logic [3:0] PAT [4][NUM_PAT][PAT_LEN] = '{
    '{'{4'd5, 4'd5, 4'd5, 4'd6, 4'd5, 4'd5, 4'd5, 4'd6},
      '{4'd5, 4'd5, 4'd6, 4'd5, 4'd5, 4'd6, 4'd5, 4'd6},
      '{4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6},
      '{4'd6, 4'd5, 4'd6, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6},
      '{4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd5}},
    '{'{4'd5, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6},
      '{4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
      '{4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
      '{4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
      '{4'd7, 4'd6, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd6}},
    '{'{4'd10, 4'd11, 4'd11, 4'd11, 4'd10, 4'd11, 4'd11, 4'd11},
      '{4'd10, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11},
      '{4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11},
      '{4'd12, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11},
      '{4'd12, 4'd11, 4'd11, 4'd11, 4'd12, 4'd11, 4'd11, 4'd11}},
    '{'{4'd11, 4'd12, 4'd12, 4'd12, 4'd11, 4'd12, 4'd12, 4'd12},
      '{4'd11, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12},
      '{4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12},
      '{4'd13, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12},
      '{4'd13, 4'd12, 4'd12, 4'd12, 4'd13, 4'd12, 4'd12, 4'd12}}
  };

  // Pack one pattern into a ring row, entry 0 in the low nibble
  function automatic logic [ROW_W-1:0] pat_row(input logic [1:0] rate,
                                               input logic [2:0] sel);
    logic [ROW_W-1:0] row;
    row = '0;
    if (sel <= 3'(NUM_PAT - 1)) begin
      for (int i = 0; i < PAT_LEN; i++) begin
        row[i*FRAME_W +: FRAME_W] = PAT[rate][sel][i];
      end
    end
    return row;
  endfunction

endpackage

// ===== rtl/core/feedback_frame_count_queue_top.sv =====
// Path: an accepted transaction passes the queue and the result register; a playback
//   request served from the ring also passes the ring read.
// Throughput: one transaction per cycle while results are taken; ring pops stall in the read state.
// The input side keeps accepting while a result waits, until the two-entry queue fills.
// Reset (rst, synchronous, active high) clears indexes, flags, counters, the queue and the
//   result valid flag, and sets rate_select to 48k; ring contents stay undefined, no clear pass.
module feedback_frame_count_queue_top #(
  parameter int RING_DEPTH   = 128,
  parameter int WARMUP_LEVEL = 80,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel: rate select register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  rate_select,
  // input transaction channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  fb_byte,
  input  logic        packet_good,
  input  logic        last_packet,
  // result transaction channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  frame_count,
  output logic        underrun,
  output logic        silent,
  output logic        synced,
  output logic        warmed_up,
  output logic [6:0]  occupancy,
  output logic [31:0] overrun_total,
  output logic [31:0] underrun_total,
  output logic [7:0]  last_feedback
);

  // rate select: 0 = 44.1k, 1 = 48k, 2 = 88.2k, 3 = 96k
  localparam logic [1:0] RATE_RESET = 2'd1;

  logic [1:0]          rate_reg;
  logic                q_valid;
  logic                q_take;
  ffcq_pkg::fq_entry_t q_entry;
  ffcq_pkg::res_t      res;

  // the user must change the register only while idle; the block does not enforce it: always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_reg <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate_reg <= rate_select;
    end
  end

  // front: decode command, check feedback window, queue the transaction
  ffcq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .rate_sel      (rate_reg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .fb_byte       (fb_byte),
    .packet_good   (packet_good),
    .last_packet   (last_packet),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_take        (q_take)
  );

  // back: ring push/pop, sync and warm-up tracking, counters, result register
  ffcq_back #(
    .RING_DEPTH  (RING_DEPTH),
    .WARMUP_LEVEL(WARMUP_LEVEL),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .rate_sel (rate_reg),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_take   (q_take),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res)
  );

  assign frame_count    = res.frame_count;
  assign underrun       = res.underrun;
  assign silent         = res.silent;
  assign synced         = res.synced;
  assign warmed_up      = res.warmed_up;
  assign occupancy      = res.occupancy;
  assign overrun_total  = res.overrun_total;
  assign underrun_total = res.underrun_total;
  assign last_feedback  = res.last_feedback;

endmodule

// ===== rtl/core/ffcq_ram.sv =====
module ffcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/ffcq_front.sv =====
module ffcq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           rate_sel,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [7:0]           fb_byte,
  input  logic                 packet_good,
  input  logic                 last_packet,
  output logic                 q_valid,
  output ffcq_pkg::fq_entry_t  q_entry,
  input  logic                 q_take
);

  // two-entry queue between classifier and executor
  ffcq_pkg::fq_entry_t slots [2];
  ffcq_pkg::fq_entry_t entry_new;
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;
  logic                pop;
  logic [7:0]          diff;

  always_comb begin
    diff = fb_byte - ffcq_pkg::WIN_BASE[rate_sel];
    entry_new.value   = fb_byte;
    entry_new.good    = packet_good;
    entry_new.last    = last_packet;
    entry_new.win_hit = (fb_byte >= ffcq_pkg::WIN_BASE[rate_sel]) &&
                        (diff <= ffcq_pkg::WIN_SPAN);
    entry_new.pat_sel = diff[2:0];
    case (cmd)
      ffcq_pkg::CMD_FEEDBACK: entry_new.kind = ffcq_pkg::OP_FEEDBACK;
      ffcq_pkg::CMD_XFER_ERR: entry_new.kind = ffcq_pkg::OP_XFER_ERR;
      ffcq_pkg::CMD_PLAYBACK: entry_new.kind = ffcq_pkg::OP_PLAYBACK;
      default:                entry_new.kind = ffcq_pkg::OP_NONE;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_entry  = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_new;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not advance on push");
`endif

endmodule

// ===== rtl/core/ffcq_back.sv =====
module ffcq_back #(
  parameter int RING_DEPTH   = 128,
  parameter int WARMUP_LEVEL = 80,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          rate_sel,
  input  logic                q_valid,
  input  ffcq_pkg::fq_entry_t q_entry,
  output logic                q_take,
  output logic                out_valid,
  input  logic                out_ready,
  output ffcq_pkg::res_t      res
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int ROWS   = RING_DEPTH / ffcq_pkg::PAT_LEN;
  localparam int ROW_AW = IDX_W - ffcq_pkg::PAT_SHIFT;

  typedef enum logic {S_RUN, S_READ} state_t;

  state_t                   state;
  logic [ROW_AW-1:0]        write_row;
  logic [IDX_W-1:0]         read_index;
  logic                     sync_flag;
  logic                     warm_flag;
  logic                     lost;
  logic [COUNT_WIDTH-1:0]   ovr_cnt;
  logic [COUNT_WIDTH-1:0]   und_cnt;
  logic [7:0]               fb_hold;
  logic [2:0]               nib_sel;

  logic [IDX_W-1:0]         write_index;
  logic [IDX_W-1:0]         fill_cur;
  logic [IDX_W-1:0]         fill_post;
  logic [IDX_W-1:0]         fill_idle;
  logic                     out_free;
  logic                     out_load;
  logic                     push;
  logic                     go_read;
  logic                     lost_upd;
  logic [ROW_AW-1:0]        write_row_next;
  logic [IDX_W-1:0]         read_index_next;
  logic                     sync_next;
  logic                     warm_next;
  logic                     lost_next;
  logic [COUNT_WIDTH-1:0]   ovr_next;
  logic [COUNT_WIDTH-1:0]   und_next;
  logic [7:0]               fb_next;
  ffcq_pkg::res_t           res_next;
  ffcq_pkg::res_t           res_rd;
  logic [ffcq_pkg::ROW_W-1:0] rd_row;

  function automatic logic [IDX_W-1:0] write_index_f(input logic [ROW_AW-1:0] row);
    return {row, ffcq_pkg::PAT_SHIFT'(0)};
  endfunction

  assign write_index = {write_row, ffcq_pkg::PAT_SHIFT'(0)};
  assign fill_cur    = write_index - read_index;
  assign out_free    = !out_valid || out_ready;
  assign q_take      = (state == S_RUN) && q_valid && out_free;
  assign push        = (q_entry.kind == ffcq_pkg::OP_FEEDBACK) && q_entry.good &&
                       q_entry.win_hit;
  // result register loads from the executor, or from the ring read data in the read state
  assign out_load    = q_take ? !go_read : ((state == S_READ) && out_free);

  always_comb begin
    write_row_next  = write_row;
    read_index_next = read_index;
    sync_next       = sync_flag;
    warm_next       = warm_flag;
    lost_next       = lost;
    ovr_next        = ovr_cnt;
    und_next        = und_cnt;
    fb_next         = fb_hold;
    go_read         = 1'b0;
    lost_upd        = lost || !(q_entry.good && q_entry.win_hit);
    fill_post       = push ? fill_cur + IDX_W'(ffcq_pkg::PAT_LEN) : fill_cur;
    res_next        = '0;
    case (q_entry.kind)
      ffcq_pkg::OP_FEEDBACK: begin
        if (q_entry.good) begin
          fb_next = q_entry.value;
        end
        if (push) begin
          if (32'(fill_cur) > 32'(RING_DEPTH - 16)) begin
            ovr_next = ovr_cnt + COUNT_WIDTH'(1);
          end
          write_row_next = write_row + ROW_AW'(1);
        end
        lost_next = lost_upd;
        if (q_entry.last) begin
          if (lost_upd) begin
            sync_next = 1'b0;
            warm_next = 1'b0;
          end else begin
            sync_next = 1'b1;
            if (32'(fill_post) >= 32'(WARMUP_LEVEL)) begin
              warm_next = 1'b1;
            end
          end
          lost_next = 1'b0;
        end
      end
      ffcq_pkg::OP_XFER_ERR: begin
        sync_next = 1'b0;
        warm_next = 1'b0;
        lost_next = 1'b0;
      end
      ffcq_pkg::OP_PLAYBACK: begin
        if (!warm_flag) begin
          res_next.frame_count = ffcq_pkg::NOMINAL[rate_sel];
          res_next.silent      = 1'b1;
        end else if (fill_cur == '0) begin
          res_next.frame_count = ffcq_pkg::NOMINAL[rate_sel];
          res_next.underrun    = 1'b1;
          und_next             = und_cnt + COUNT_WIDTH'(1);
        end else begin
          go_read         = 1'b1;
          read_index_next = read_index + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
    res_next.synced         = sync_next;
    res_next.warmed_up      = warm_next;
    res_next.occupancy      = 7'(write_index_f(write_row_next) - read_index_next);
    res_next.overrun_total  = 32'(ovr_next);
    res_next.underrun_total = 32'(und_next);
    res_next.last_feedback  = fb_next;
  end

  // ring pop completes here: nothing else moved since the read was issued
  always_comb begin
    fill_idle              = fill_cur;
    res_rd                 = '0;
    res_rd.frame_count     = rd_row[nib_sel*ffcq_pkg::FRAME_W +: ffcq_pkg::FRAME_W];
    res_rd.synced          = sync_flag;
    res_rd.warmed_up       = warm_flag;
    res_rd.occupancy       = 7'(fill_idle);
    res_rd.overrun_total   = 32'(ovr_cnt);
    res_rd.underrun_total  = 32'(und_cnt);
    res_rd.last_feedback   = fb_hold;
  end

  ffcq_ram #(
    .WIDTH(ffcq_pkg::ROW_W),
    .DEPTH(ROWS)
  ) u_ring (
    .clk    (clk),
    .wr_en  (q_take && push),
    .wr_addr(write_row),
    .wr_data(ffcq_pkg::pat_row(rate_sel, q_entry.pat_sel)),
    .rd_en  (q_take && go_read),
    .rd_addr(read_index[IDX_W-1:ffcq_pkg::PAT_SHIFT]),
    .rd_data(rd_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RUN;
      out_valid  <= 1'b0;
      write_row  <= '0;
      read_index <= '0;
      sync_flag  <= 1'b0;
      warm_flag  <= 1'b0;
      lost       <= 1'b0;
      ovr_cnt    <= '0;
      und_cnt    <= '0;
      fb_hold    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          if (q_take) begin
            write_row  <= write_row_next;
            read_index <= read_index_next;
            sync_flag  <= sync_next;
            warm_flag  <= warm_next;
            lost       <= lost_next;
            ovr_cnt    <= ovr_next;
            und_cnt    <= und_next;
            fb_hold    <= fb_next;
            if (go_read) begin
              nib_sel <= read_index[ffcq_pkg::PAT_SHIFT-1:0];
              state   <= S_READ;
            end else begin
              res <= res_next;
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            res   <= res_rd;
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_read_then_wait: assert property (@(posedge clk) disable iff (rst)
    (q_take && go_read) |=> (state == S_READ))
    else $error("ring read issued without entering read state");

  a_warm_needs_sync: assert property (@(posedge clk) disable iff (rst)
    warm_flag |-> sync_flag)
    else $error("warm-up flag set while not synced");

  a_no_pop_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> $stable(read_index) || $past(out_free))
    else $error("read index moved while a ring read was pending");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;

  // Expected behavior constants
  localparam logic [6:0] OVERRUN_FILL = 7'd112;
  localparam logic [6:0] WARM_FILL    = 7'd80;
  localparam logic [7:0] WINDOW_LO [4] = '{8'd42, 8'd46, 8'd86, 8'd94};
  localparam logic [3:0] NOM_FRAMES [4] = '{4'd5, 4'd6, 4'd11, 4'd12};
  localparam logic [3:0] FRAMES_PER_PKT [4][5][8] = '{
    '{'{4'd5, 4'd5, 4'd5, 4'd6, 4'd5, 4'd5, 4'd5, 4'd6},
      '{4'd5, 4'd5, 4'd6, 4'd5, 4'd5, 4'd6, 4'd5, 4'd6},
      '{4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6},
      '{4'd6, 4'd5, 4'd6, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6},
      '{4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd5}},
    '{'{4'd5, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6},
      '{4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
      '{4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
      '{4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
      '{4'd7, 4'd6, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd6}},
    '{'{4'd10, 4'd11, 4'd11, 4'd11, 4'd10, 4'd11, 4'd11, 4'd11},
      '{4'd10, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11},
      '{4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11},
      '{4'd12, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11},
      '{4'd12, 4'd11, 4'd11, 4'd11, 4'd12, 4'd11, 4'd11, 4'd11}},
    '{'{4'd11, 4'd12, 4'd12, 4'd12, 4'd11, 4'd12, 4'd12, 4'd12},
      '{4'd11, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12},
      '{4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12},
      '{4'd13, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12},
      '{4'd13, 4'd12, 4'd12, 4'd12, 4'd13, 4'd12, 4'd12, 4'd12}}
  };

  // Rate for each random phase: both extremes, every rate at least once
  localparam logic [1:0] PHASE_RATE [6] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0};

  // One input transaction
  typedef struct packed {
    ffcq_pkg::op_kind_t op;
    logic [7:0]         value;
    logic               good;
    logic               last;
  } fb_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  rate_select = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = 2'd0;
  logic [7:0]  fb_byte = 8'd0;
  logic        packet_good = 1'b0;
  logic        last_packet = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  frame_count;
  logic        underrun;
  logic        silent;
  logic        synced;
  logic        warmed_up;
  logic [6:0]  occupancy;
  logic [31:0] overrun_total;
  logic [31:0] underrun_total;
  logic [7:0]  last_feedback;

  // Stimulus and scoreboard storage
  fb_event_t      event_q[$];          // transactions waiting to be offered
  fb_event_t      cur_event;           // transaction currently on the input port
  ffcq_pkg::res_t expected_status[$];  // predicted results, oldest first
  int             events_accepted = 0;
  int             status_errors = 0;
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  logic           rx_hold = 1'b0;

  // Shadow copy of the block state
  logic [3:0]  ring [128];
  logic [6:0]  wr_ptr = 7'd0;
  logic [6:0]  rd_ptr = 7'd0;
  logic        sync_q = 1'b0;
  logic        warm_q = 1'b0;
  logic        lost_q = 1'b0;
  logic [31:0] overrun_cnt = 32'd0;
  logic [31:0] underrun_cnt = 32'd0;
  logic [7:0]  fb_hold = 8'd0;
  logic [1:0]  rate_now = 2'd1;   // reset value of the register: 48k

  feedback_frame_count_queue_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .rate_select    (rate_select),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .fb_byte        (fb_byte),
    .packet_good    (packet_good),
    .last_packet    (last_packet),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_count    (frame_count),
    .underrun       (underrun),
    .silent         (silent),
    .synced         (synced),
    .warmed_up      (warmed_up),
    .occupancy      (occupancy),
    .overrun_total  (overrun_total),
    .underrun_total (underrun_total),
    .last_feedback  (last_feedback)
  );

  always #1 clk = ~clk;

  // Ring occupancy, wraps with the 7-bit pointers
  function automatic logic [6:0] ring_fill();
    return wr_ptr - rd_ptr;
  endfunction

  // Advance the shadow state by one transaction and return the status it leaves
  function automatic ffcq_pkg::res_t predict_event_status(input fb_event_t ev);
    ffcq_pkg::res_t st;
    logic [7:0]     lo;
    logic [2:0]     sel;
    logic [6:0]     slot;
    int             i;
    st = '0;
    lo = WINDOW_LO[rate_now];
    case (ev.op)
      ffcq_pkg::OP_FEEDBACK: begin
        if (ev.good) begin
          fb_hold = ev.value;
          if (ev.value >= lo && ev.value <= lo + 8'd4) begin
            sel = 3'(ev.value - lo);
            // overrun is judged on the fill before the push
            if (ring_fill() > OVERRUN_FILL) overrun_cnt = overrun_cnt + 32'd1;
            for (i = 0; i < 8; i++) begin
              slot = wr_ptr + 7'(i);
              ring[slot] = FRAMES_PER_PKT[rate_now][sel][i];
            end
            wr_ptr = wr_ptr + 7'd8;
          end else begin
            lost_q = 1'b1;
          end
        end else begin
          lost_q = 1'b1;
        end
        // sync and warm-up are only evaluated at the end of a transfer
        if (ev.last) begin
          if (lost_q) begin
            sync_q = 1'b0;
            warm_q = 1'b0;
          end else begin
            sync_q = 1'b1;
            if (ring_fill() >= WARM_FILL) warm_q = 1'b1;
          end
          lost_q = 1'b0;
        end
      end
      ffcq_pkg::OP_XFER_ERR: begin
        sync_q = 1'b0;
        warm_q = 1'b0;
        lost_q = 1'b0;
      end
      ffcq_pkg::OP_PLAYBACK: begin
        if (!warm_q) begin
          st.frame_count = NOM_FRAMES[rate_now];
          st.silent      = 1'b1;
        end else if (rd_ptr == wr_ptr) begin
          underrun_cnt   = underrun_cnt + 32'd1;
          st.frame_count = NOM_FRAMES[rate_now];
          st.underrun    = 1'b1;
        end else begin
          st.frame_count = ring[rd_ptr];
          rd_ptr = rd_ptr + 7'd1;
        end
      end
      default: begin
      end
    endcase
    st.synced         = sync_q;
    st.warmed_up      = warm_q;
    st.occupancy      = ring_fill();
    st.overrun_total  = overrun_cnt;
    st.underrun_total = underrun_cnt;
    st.last_feedback  = fb_hold;
    return st;
  endfunction

  function automatic fb_event_t mk_event(input ffcq_pkg::op_kind_t op,
                                         input logic [7:0] value,
                                         input logic good, input logic last);
    fb_event_t ev;
    ev.op    = op;
    ev.value = value;
    ev.good  = good;
    ev.last  = last;
    return ev;
  endfunction

  // Input driver: offers queued transactions, predicts each one as it is accepted.
  // Valid is only dropped when no transaction is on the port.
  always @(posedge clk) begin : drive_events
    fb_event_t nxt;
    logic      free;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      free = !in_valid || in_ready;
      if (in_valid && in_ready) begin
        expected_status.push_back(predict_event_status(cur_event));
        events_accepted++;
      end
      if (free) begin
        if (event_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = event_q.pop_front();
          cur_event   <= nxt;
          in_valid    <= 1'b1;
          cmd         <= nxt.op;
          fb_byte     <= nxt.value;
          packet_good <= nxt.good;
          last_packet <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side backpressure; rx_hold forces a long stall
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (status_errors < 10) begin
        $display("mismatch on %s at %0t: expected %0d, got %0d", name, $realtime, want, got);
      end
      status_errors++;
    end
  endtask

  // Monitor: every accepted result is matched against the oldest prediction
  always @(posedge clk) begin : watch_status
    ffcq_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        if (status_errors < 10) begin
          $display("unexpected result transaction at %0t", $realtime);
        end
        status_errors++;
      end else begin
        want = expected_status.pop_front();
        check_field("frame_count", want.frame_count, frame_count);
        check_field("underrun", want.underrun, underrun);
        check_field("silent", want.silent, silent);
        check_field("synced", want.synced, synced);
        check_field("warmed_up", want.warmed_up, warmed_up);
        check_field("occupancy", want.occupancy, occupancy);
        check_field("overrun_total", want.overrun_total, overrun_total);
        check_field("underrun_total", want.underrun_total, underrun_total);
        check_field("last_feedback", want.last_feedback, last_feedback);
      end
    end
  end

  // Register write; only called while the block is idle, so the shadow
  // rate can change at the accepting edge
  task automatic write_rate(input logic [1:0] value);
    @(posedge clk);
    cfg_valid   <= 1'b1;
    rate_select <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate_now = value;
  endtask

  // Sender holds off until every prediction has been matched, then lets
  // the pipeline settle
  task automatic wait_idle();
    do @(posedge clk);
    while (event_q.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // Random traffic: mostly well-formed transfers of in-window packets and
  // playback requests, with broken transfers, errors and noise mixed in
  task automatic queue_random_events(input int n);
    int         made;
    int         pick;
    int         len;
    int         bad_at;
    int         fb_share;
    int         k;
    logic [7:0] lo;
    made = 0;
    // push share around the pop rate so the ring both fills and drains
    fb_share = $urandom_range(6, 14);
    lo = WINDOW_LO[rate_now];
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < fb_share) begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) begin
          event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK, lo + 8'($urandom_range(0, 4)),
                                     1'b1, k == len - 1));
        end
        made += len;
      end else if (pick < fb_share + 3) begin
        // one packet of the transfer is corrupt, the end mark may be missing
        len = $urandom_range(1, 3);
        bad_at = $urandom_range(0, len - 1);
        for (k = 0; k < len; k++) begin
          if (k == bad_at) begin
            event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK, 8'($urandom), 1'($urandom),
                                       (k == len - 1) && ($urandom_range(0, 3) != 0)));
          end else begin
            event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK,
                                       lo + 8'($urandom_range(0, 4)), 1'b1,
                                       (k == len - 1) && ($urandom_range(0, 3) != 0)));
          end
        end
        made += len;
      end else if (pick < fb_share + 5) begin
        event_q.push_back(mk_event(ffcq_pkg::OP_XFER_ERR, 8'($urandom), 1'($urandom),
                                   1'($urandom)));
        made++;
      end else if (pick < fb_share + 7) begin
        // unused command, not counted
        event_q.push_back(mk_event(ffcq_pkg::OP_NONE, 8'($urandom), 1'($urandom),
                                   1'($urandom)));
      end else if (pick < fb_share + 10) begin
        event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK, 8'($urandom), 1'($urandom),
                                   1'($urandom)));
        made++;
      end else begin
        event_q.push_back(mk_event(ffcq_pkg::OP_PLAYBACK, 8'($urandom), 1'($urandom),
                                   1'($urandom)));
        made++;
      end
    end
  endtask

  // Long receiver stall in the middle of a random phase; the sender keeps
  // offering, so the block's queue fills and in_ready drops
  initial begin
    wait (events_accepted >= 260 && event_q.size() > 20);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog
  initial begin
    #400000;
    $display("tb failed");
    $finish;
  end

  // Main sequence
  initial begin : run_test
    int ph;
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // sender 12%, receiver 45% idle for the first phases
    tx_idle_pct <= 12;
    rx_idle_pct <= 45;

    // Directed part at the reset rate (48k, window 46..50)
    event_q.push_back(mk_event(ffcq_pkg::OP_PLAYBACK, 8'd0, 1'b0, 1'b0));  // not warm: silent
    event_q.push_back(mk_event(ffcq_pkg::OP_NONE, 8'hFF, 1'b1, 1'b1));     // unused command
    event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK, 8'hFF, 1'b0, 1'b1)); // bad packet
    event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK, 8'h00, 1'b1, 1'b1)); // far outside window
    event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK, 8'd45, 1'b1, 1'b0)); // just below window
    event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK, 8'd51, 1'b1, 1'b1)); // just above window
    event_q.push_back(mk_event(ffcq_pkg::OP_XFER_ERR, 8'hFF, 1'b1, 1'b1));
    // 16 pushes: transfer ends at fill 80 (warm threshold), push 15 sees
    // fill 112 (no overrun), push 16 sees 120 and wraps the ring
    for (k = 0; k < 16; k++) begin
      event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK, 8'd46 + 8'(k % 5), 1'b1, k == 9));
    end
    event_q.push_back(mk_event(ffcq_pkg::OP_PLAYBACK, 8'hFF, 1'b1, 1'b1)); // warm, empty
    event_q.push_back(mk_event(ffcq_pkg::OP_FEEDBACK, 8'd50, 1'b1, 1'b0)); // top of window
    event_q.push_back(mk_event(ffcq_pkg::OP_PLAYBACK, 8'd0, 1'b0, 1'b0));  // pop from ring
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      write_rate(PHASE_RATE[ph]);
      if (ph == 2) begin
        tx_idle_pct <= 45;
        rx_idle_pct <= 12;
      end else if (ph == 4) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      queue_random_events(100);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (status_errors == 0 && expected_status.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
